// ----- rtl/hmq_pkg.sv -----
// shared types and codes for the binary min-heap queue
package hmq_pkg;

	// operation codes carried in the action field
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// result status codes
	localparam int STATUS_BITS = 2;
	localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	// where a level cell takes its write data from
	typedef enum logic [1:0] {
		WS_MOVER,
		WS_PARENT,
		WS_CHILD
	} hmq_wsrc_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic      rd_en;
		logic      wr_en;
		hmq_wsrc_t wr_src;
		logic      c2_ok;
	} hmq_cell_ctl_t;

endpackage

// ----- rtl/hmq_ifs.sv -----
// request and response channel interfaces of the heap queue

interface hmq_req_if #(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
);
	logic                    valid;
	logic                    ready;
	logic                    action;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source(output valid, action, key, payload, input ready);
	modport sink(input valid, action, key, payload, output ready);
endinterface

interface hmq_rsp_if
	import hmq_pkg::*;
#(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16,
	parameter int OCC_BITS     = 7
);
	logic                    valid;
	logic                    ready;
	logic [KEY_BITS-1:0]     out_key;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [STATUS_BITS-1:0]  status;
	logic [OCC_BITS-1:0]     occupancy;

	modport source(output valid, out_key, out_payload, status, occupancy, input ready);
	modport sink(input valid, out_key, out_payload, status, occupancy, output ready);
endinterface

// ----- rtl/hmq_cell.sv -----
// one heap level: sibling-pair storage, registered pair read and smaller-child pick
module hmq_cell
	import hmq_pkg::*;
#(
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16,
	parameter int OFF_BITS     = 7,
	parameter int CELL_DEPTH   = 1
) (
	input  logic                         clk,
	input  hmq_cell_ctl_t                ctl,
	input  logic [OFF_BITS-1:0]          rd_row,
	input  logic [OFF_BITS-1:0]          wr_off,
	input  logic [KEY_BITS-1:0]          mov_key,
	input  logic [PAYLOAD_BITS-1:0]      mov_pay,
	input  logic [1:0][KEY_BITS-1:0]     up_key,
	input  logic [1:0][PAYLOAD_BITS-1:0] up_pay,
	input  logic [KEY_BITS-1:0]          dn_key,
	input  logic [PAYLOAD_BITS-1:0]      dn_pay,
	output logic [1:0][KEY_BITS-1:0]     pair_key_q,
	output logic [1:0][PAYLOAD_BITS-1:0] pair_pay_q,
	output logic [KEY_BITS-1:0]          pick_key,
	output logic [PAYLOAD_BITS-1:0]      pick_pay,
	output logic                         pick_bit
);

	localparam int ROWS     = (CELL_DEPTH + 1) / 2;
	localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [1:0][KEY_BITS-1:0]     mem_key [ROWS];
	logic [1:0][PAYLOAD_BITS-1:0] mem_pay [ROWS];

	logic [ROW_BITS-1:0]     rd_idx;
	logic [ROW_BITS-1:0]     wr_idx;
	logic                    wr_half;
	logic [KEY_BITS-1:0]     wr_key;
	logic [PAYLOAD_BITS-1:0] wr_pay;

	assign rd_idx  = rd_row[ROW_BITS-1:0];
	assign wr_idx  = wr_off[ROW_BITS:1];
	assign wr_half = wr_off[0];

	// write data: the moving entry, the parent level's entry, or the child level's pick
	always_comb begin
		case (ctl.wr_src)
			WS_PARENT: begin
				wr_key = up_key[wr_off[1]];
				wr_pay = up_pay[wr_off[1]];
			end
			WS_CHILD: begin
				wr_key = dn_key;
				wr_pay = dn_pay;
			end
			default: begin
				wr_key = mov_key;
				wr_pay = mov_pay;
			end
		endcase
	end

	// level storage with registered pair read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_key[wr_idx][wr_half] <= wr_key;
			mem_pay[wr_idx][wr_half] <= wr_pay;
		end
		if (ctl.rd_en) begin
			pair_key_q <= mem_key[rd_idx];
			pair_pay_q <= mem_pay[rd_idx];
		end
	end

	// smaller child, first child wins ties
	assign pick_bit = ctl.c2_ok && (pair_key_q[1] < pair_key_q[0]);
	assign pick_key = pair_key_q[pick_bit];
	assign pick_pay = pair_pay_q[pick_bit];

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
// binary min-heap priority queue built from a chain of per-level cells
//
//   channel  dir  transaction                       fields
//   req      in   one insert or remove operation     action, key, payload
//   rsp      out  one result per operation           out_key, out_payload, status, occupancy
//
// one operation at a time; an insert climbs level by level from the tail toward the root, and a
// remove moves the last entry to the root and descends level by level. each level step is a
// registered read of the neighbor cell followed by a compare-and-write step. error operations
// (full insert, empty remove) go straight to the result state.
// arst_n clears the entry count; entry storage has no reset and no clearing pass.
// a waiting result does not block the next request; only a finished result waits
// for the response register to drain.
module binary_min_heap_queue
	import hmq_pkg::*;
#(
	parameter int HEAP_DEPTH   = 64,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	hmq_req_if.sink    req,
	hmq_rsp_if.source  rsp
);

	localparam int NLEV     = $clog2(HEAP_DEPTH + 1);
	localparam int OFF_BITS = NLEV;
	localparam int LVL_BITS = $clog2(NLEV);
	localparam int TL_BITS  = $clog2(NLEV + 1);
	localparam int CNT_BITS = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_READ,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_READ,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [TL_BITS-1:0]      tl_q;
	logic [OFF_BITS-1:0]     to_q;
	logic [LVL_BITS-1:0]     lvl_q;
	logic [OFF_BITS-1:0]     off_q;
	logic [KEY_BITS-1:0]     mov_key_q;
	logic [PAYLOAD_BITS-1:0] mov_pay_q;
	logic [KEY_BITS-1:0]     res_key_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;
	logic [STATUS_BITS-1:0]  res_status_q;
	logic                    out_valid_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic [STATUS_BITS-1:0]  out_status_q;
	logic [CNT_BITS-1:0]     out_occ_q;

	// cell-side buses
	hmq_cell_ctl_t                cell_ctl [NLEV];
	logic [OFF_BITS-1:0]          rd_row   [NLEV];
	logic [1:0][KEY_BITS-1:0]     pair_key [NLEV];
	logic [1:0][PAYLOAD_BITS-1:0] pair_pay [NLEV];
	logic [KEY_BITS-1:0]          pick_key [NLEV];
	logic [PAYLOAD_BITS-1:0]      pick_pay [NLEV];
	logic                         pick_bit [NLEV];
	logic [1:0][KEY_BITS-1:0]     up_key_w [NLEV];
	logic [1:0][PAYLOAD_BITS-1:0] up_pay_w [NLEV];
	logic [KEY_BITS-1:0]          dn_key_w [NLEV];
	logic [PAYLOAD_BITS-1:0]      dn_pay_w [NLEV];

	// tail position (level, offset) of the next free slot, stepped up and down
	logic [OFF_BITS:0]   pow_t;
	logic [OFF_BITS:0]   to_p1;
	logic [TL_BITS-1:0]  tl_i;
	logic [OFF_BITS-1:0] to_i;
	logic [TL_BITS-1:0]  tl_d;
	logic [OFF_BITS:0]   pow_d;
	logic [OFF_BITS-1:0] to_d;

	assign pow_t = (OFF_BITS + 1)'(1) << tl_q;
	assign to_p1 = {1'b0, to_q} + 1'b1;
	assign tl_i  = (to_p1 == pow_t) ? tl_q + 1'b1 : tl_q;
	assign to_i  = (to_p1 == pow_t) ? '0 : to_p1[OFF_BITS-1:0];
	assign tl_d  = (to_q == '0) ? tl_q - 1'b1 : tl_q;
	assign pow_d = (OFF_BITS + 1)'(1) << tl_d;
	assign to_d  = (to_q == '0) ? OFF_BITS'(pow_d - 1'b1) : to_q - 1'b1;

	// neighbor levels of the current position
	logic [LVL_BITS-1:0] lvl_m1;
	logic [LVL_BITS-1:0] lvl_p1;
	logic [TL_BITS-1:0]  clvl;
	logic [OFF_BITS:0]   c1_off;
	logic [OFF_BITS:0]   c2_off;
	logic                c1_ok;
	logic                c2_ok;

	assign lvl_m1 = lvl_q - 1'b1;
	assign lvl_p1 = lvl_q + 1'b1;
	assign clvl   = TL_BITS'(lvl_q) + 1'b1;
	assign c1_off = {off_q, 1'b0};
	assign c2_off = {off_q, 1'b1};
	assign c1_ok  = (clvl < tl_q) || ((clvl == tl_q) && (c1_off < {1'b0, to_q}));
	assign c2_ok  = (clvl < tl_q) || ((clvl == tl_q) && (c2_off < {1'b0, to_q}));

	// compare operands for the sift steps
	logic [KEY_BITS-1:0]     par_key;
	logic [KEY_BITS-1:0]     chd_key;
	logic                    chd_bit;
	logic                    up_stop;
	logic                    dn_stop;

	assign par_key = pair_key[lvl_m1][off_q[1]];
	assign chd_key = pick_key[lvl_p1];
	assign chd_bit = pick_bit[lvl_p1];
	assign up_stop = !(mov_key_q < par_key);
	assign dn_stop = !(chd_key < mov_key_q);

	logic accept;
	logic out_load;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// level cells
	for (genvar g = 0; g < NLEV; g++) begin : g_cell
		localparam int LSIZE  = 1 << g;
		localparam int AVAIL  = HEAP_DEPTH - LSIZE + 1;
		localparam int CDEPTH = (AVAIL < LSIZE) ? AVAIL : LSIZE;

		if (g == 0) begin : g_top
			assign up_key_w[g] = '0;
			assign up_pay_w[g] = '0;
		end else begin : g_mid
			assign up_key_w[g] = pair_key[g-1];
			assign up_pay_w[g] = pair_pay[g-1];
		end

		if (g == NLEV - 1) begin : g_leaf
			assign dn_key_w[g] = '0;
			assign dn_pay_w[g] = '0;
		end else begin : g_inner
			assign dn_key_w[g] = pick_key[g+1];
			assign dn_pay_w[g] = pick_pay[g+1];
		end

		hmq_cell #(
			.KEY_BITS     (KEY_BITS),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.OFF_BITS     (OFF_BITS),
			.CELL_DEPTH   (CDEPTH)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[g]),
			.rd_row     (rd_row[g]),
			.wr_off     (off_q),
			.mov_key    (mov_key_q),
			.mov_pay    (mov_pay_q),
			.up_key     (up_key_w[g]),
			.up_pay     (up_pay_w[g]),
			.dn_key     (dn_key_w[g]),
			.dn_pay     (dn_pay_w[g]),
			.pair_key_q (pair_key[g]),
			.pair_pay_q (pair_pay[g]),
			.pick_key   (pick_key[g]),
			.pick_pay   (pick_pay[g]),
			.pick_bit   (pick_bit[g])
		);
	end

	// per-level read and write strobes
	always_comb begin
		logic is_cur;
		logic is_par;
		logic is_chd;
		logic is_last;
		for (int l = 0; l < NLEV; l++) begin
			is_cur  = (LVL_BITS'(l) == lvl_q);
			is_par  = (LVL_BITS'(l) == lvl_m1);
			is_chd  = (LVL_BITS'(l) == lvl_p1);
			is_last = (TL_BITS'(l) == tl_d);
			cell_ctl[l] = '{rd_en: 1'b0, wr_en: 1'b0, wr_src: WS_MOVER, c2_ok: c2_ok};
			rd_row[l]   = '0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.action == ACT_REMOVE && count_q != '0) begin
						if (l == 0) begin
							cell_ctl[l].rd_en = 1'b1;
						end else if (is_last) begin
							cell_ctl[l].rd_en = 1'b1;
							rd_row[l]         = to_d >> 1;
						end
					end
				end
				S_UP_READ: begin
					if (lvl_q == '0) begin
						cell_ctl[l].wr_en = is_cur;
					end else if (is_par) begin
						cell_ctl[l].rd_en = 1'b1;
						rd_row[l]         = off_q >> 2;
					end
				end
				S_UP_CMP: begin
					cell_ctl[l].wr_en  = is_cur;
					cell_ctl[l].wr_src = up_stop ? WS_MOVER : WS_PARENT;
				end
				S_DN_READ: begin
					if (!c1_ok) begin
						cell_ctl[l].wr_en = is_cur;
					end else if (is_chd) begin
						cell_ctl[l].rd_en = 1'b1;
						rd_row[l]         = off_q;
					end
				end
				S_DN_CMP: begin
					cell_ctl[l].wr_en  = is_cur;
					cell_ctl[l].wr_src = dn_stop ? WS_MOVER : WS_CHILD;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer, entry count, tail and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			tl_q         <= '0;
			to_q         <= '0;
			lvl_q        <= '0;
			off_q        <= '0;
			mov_key_q    <= '0;
			mov_pay_q    <= '0;
			res_key_q    <= '0;
			res_pay_q    <= '0;
			res_status_q <= ST_DONE;
			out_valid_q  <= 1'b0;
			out_key_q    <= '0;
			out_pay_q    <= '0;
			out_status_q <= ST_DONE;
			out_occ_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_key_q    <= res_key_q;
				out_pay_q    <= res_pay_q;
				out_status_q <= res_status_q;
				out_occ_q    <= count_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_key_q    <= '0;
						res_pay_q    <= '0;
						res_status_q <= ST_DONE;
						if (req.action == ACT_INSERT) begin
							if (count_q == CNT_BITS'(HEAP_DEPTH)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_DONE;
							end else begin
								mov_key_q <= req.key;
								mov_pay_q <= req.payload;
								lvl_q     <= LVL_BITS'(tl_q);
								off_q     <= to_q;
								count_q   <= count_q + 1'b1;
								tl_q      <= tl_i;
								to_q      <= to_i;
								state_q   <= S_UP_READ;
							end
						end else begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_DONE;
							end else begin
								// remember where the last entry sits
								lvl_q   <= LVL_BITS'(tl_d);
								off_q   <= to_d;
								count_q <= count_q - 1'b1;
								tl_q    <= tl_d;
								to_q    <= to_d;
								state_q <= S_DN_LOAD;
							end
						end
					end
				end
				S_UP_READ: begin
					state_q <= (lvl_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_stop) begin
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_m1;
						off_q   <= off_q >> 1;
						state_q <= S_UP_READ;
					end
				end
				S_DN_LOAD: begin
					res_key_q <= pair_key[0][0];
					res_pay_q <= pair_pay[0][0];
					mov_key_q <= pair_key[lvl_q][off_q[0]];
					mov_pay_q <= pair_pay[lvl_q][off_q[0]];
					lvl_q     <= '0;
					off_q     <= '0;
					state_q   <= S_DN_READ;
				end
				S_DN_READ: begin
					state_q <= c1_ok ? S_DN_CMP : S_DONE;
				end
				S_DN_CMP: begin
					if (dn_stop) begin
						state_q <= S_DONE;
					end else begin
						lvl_q   <= lvl_p1;
						off_q   <= c1_off[OFF_BITS-1:0] | OFF_BITS'(chd_bit);
						state_q <= S_DN_READ;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response channel
	assign rsp.valid       = out_valid_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_payload = out_pay_q;
	assign rsp.status      = out_status_q;
	assign rsp.occupancy   = out_occ_q;

`ifndef SYNTHESIS
	// entry count stays within the array
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	// tail position always names the slot at index count
	a_tail_match: assert property (@(posedge clk) disable iff (!arst_n)
		((32'(1) << tl_q) - 32'(1) + 32'(to_q)) == 32'(count_q))
		else $error("tail position out of step with entry count");

	// a successful insert grows the heap by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.action == ACT_INSERT && count_q != CNT_BITS'(HEAP_DEPTH))
		|=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add an entry");

	// a failed operation leaves the count alone
	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((req.action == ACT_INSERT && count_q == CNT_BITS'(HEAP_DEPTH)) ||
			(req.action == ACT_REMOVE && count_q == '0)))
		|=> $stable(count_q))
		else $error("rejected operation changed the entry count");
`endif

endmodule

// ----- dv/tb_binary_min_heap_queue.sv -----
// testbench for the binary min-heap queue: directed, fill/drain and random operation mixes
module tb_binary_min_heap_queue;
	import hmq_pkg::*;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int PAY_W = 16;
	localparam int OCC_W = 7;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [PAY_W-1:0] PAY_MAX = '1;

	typedef struct {
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic [STATUS_BITS-1:0] status;
		logic [OCC_W-1:0] occupancy;
	} heap_result_t;

	logic clk;
	logic arst_n;

	hmq_req_if #(.KEY_BITS(KEY_W), .PAYLOAD_BITS(PAY_W)) req_ch ();
	hmq_rsp_if #(.KEY_BITS(KEY_W), .PAYLOAD_BITS(PAY_W), .OCC_BITS(OCC_W)) rsp_ch ();

	binary_min_heap_queue #(
		.HEAP_DEPTH(DEPTH),
		.KEY_BITS(KEY_W),
		.PAYLOAD_BITS(PAY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predicted heap contents
	logic [KEY_W-1:0] heap_key_mem [DEPTH];
	logic [PAY_W-1:0] heap_pay_mem [DEPTH];
	int heap_count;

	heap_result_t heap_expect [$];
	int mismatch_count;
	int src_idle_pct;
	int sink_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial begin
		#(20 * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic swap_heap_slots(input int a, input int b);
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		k = heap_key_mem[a];
		p = heap_pay_mem[a];
		heap_key_mem[a] = heap_key_mem[b];
		heap_pay_mem[a] = heap_pay_mem[b];
		heap_key_mem[b] = k;
		heap_pay_mem[b] = p;
	endtask

	// apply one accepted operation to the predicted heap and queue its result
	task automatic predict_heap_op(input logic act, input logic [KEY_W-1:0] k,
			input logic [PAY_W-1:0] p);
		heap_result_t res;
		int at;
		int up;
		int c1;
		int pick;
		res.out_key = '0;
		res.out_payload = '0;
		res.status = ST_DONE;
		if (act == ACT_INSERT) begin
			if (heap_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				at = heap_count;
				heap_key_mem[at] = k;
				heap_pay_mem[at] = p;
				heap_count++;
				// sift up while strictly smaller than the parent
				while (at > 0) begin
					up = (at - 1) / 2;
					if (heap_key_mem[at] >= heap_key_mem[up])
						break;
					swap_heap_slots(at, up);
					at = up;
				end
			end
		end else begin
			if (heap_count == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_key = heap_key_mem[0];
				res.out_payload = heap_pay_mem[0];
				heap_count--;
				heap_key_mem[0] = heap_key_mem[heap_count];
				heap_pay_mem[0] = heap_pay_mem[heap_count];
				// sift down toward the smaller child, first child wins ties
				at = 0;
				forever begin
					c1 = 2 * at + 1;
					if (c1 >= heap_count)
						break;
					pick = c1;
					if (c1 + 1 < heap_count && heap_key_mem[c1 + 1] < heap_key_mem[c1])
						pick = c1 + 1;
					if (heap_key_mem[pick] >= heap_key_mem[at])
						break;
					swap_heap_slots(at, pick);
					at = pick;
				end
			end
		end
		res.occupancy = heap_count[OCC_W-1:0];
		heap_expect.push_back(res);
	endtask

	// drive one request transaction and wait for it to be taken
	task automatic send_heap_op(input logic act, input logic [KEY_W-1:0] k,
			input logic [PAY_W-1:0] p);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.key <= k;
		req_ch.payload <= p;
		do @(posedge clk); while (!req_ch.ready);
		predict_heap_op(act, k, p);
	endtask

	// hold off the sender until every queued result has come back
	task automatic wait_all_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (heap_expect.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return KEY_W'($urandom_range(15));
		else if (r < 40)
			return '0;
		else if (r < 45)
			return KEY_MAX;
		return KEY_W'($urandom);
	endfunction

	// receiver stalls
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		heap_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (heap_expect.size() == 0) begin
				report_mismatch("unexpected result, status", KEY_W'(rsp_ch.status), '0);
			end else begin
				want = heap_expect.pop_front();
				if (rsp_ch.out_key !== want.out_key)
					report_mismatch("out_key", rsp_ch.out_key, want.out_key);
				if (rsp_ch.out_payload !== want.out_payload)
					report_mismatch("out_payload", KEY_W'(rsp_ch.out_payload),
						KEY_W'(want.out_payload));
				if (rsp_ch.status !== want.status)
					report_mismatch("status", KEY_W'(rsp_ch.status), KEY_W'(want.status));
				if (rsp_ch.occupancy !== want.occupancy)
					report_mismatch("occupancy", KEY_W'(rsp_ch.occupancy),
						KEY_W'(want.occupancy));
			end
		end
	end

	// extremes, equal keys, empty remove
	task automatic test_edge_cases();
		send_heap_op(ACT_REMOVE, KEY_MAX, PAY_MAX);
		send_heap_op(ACT_INSERT, KEY_MAX, PAY_MAX);
		send_heap_op(ACT_INSERT, '0, '0);
		send_heap_op(ACT_INSERT, 32'd5, 16'd1);
		send_heap_op(ACT_INSERT, 32'd5, 16'd2);
		send_heap_op(ACT_INSERT, 32'd5, 16'd3);
		send_heap_op(ACT_INSERT, KEY_MAX, 16'h0001);
		send_heap_op(ACT_INSERT, 32'h8000_0000, 16'h8000);
		send_heap_op(ACT_INSERT, 32'd1, 16'haaaa);
		send_heap_op(ACT_INSERT, 32'd2, 16'h5555);
		repeat (10)
			send_heap_op(ACT_REMOVE, '0, '0);
		send_heap_op(ACT_REMOVE, 32'h5555_aaaa, 16'h1234);
		wait_all_results();
	endtask

	// fill to capacity, insert on full, drain past empty
	task automatic test_full_empty();
		repeat (DEPTH)
			send_heap_op(ACT_INSERT, pick_key(), PAY_W'($urandom));
		send_heap_op(ACT_INSERT, '0, '0);
		send_heap_op(ACT_INSERT, KEY_MAX, PAY_MAX);
		repeat (DEPTH + 1)
			send_heap_op(ACT_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
		wait_all_results();
	endtask

	// random mix that swings occupancy between empty and full
	task automatic test_random_mix(input int count);
		bit filling;
		int bias;
		filling = 1'b1;
		for (int i = 0; i < count; i++) begin
			if (heap_count >= DEPTH && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (heap_count == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			else if ($urandom_range(49) == 0)
				filling = !filling;
			bias = filling ? 75 : 25;
			if ($urandom_range(99) < bias)
				send_heap_op(ACT_INSERT, pick_key(), PAY_W'($urandom));
			else
				send_heap_op(ACT_REMOVE, KEY_W'($urandom), PAY_W'($urandom));
		end
		wait_all_results();
	endtask

	initial begin
		mismatch_count = 0;
		heap_count = 0;
		src_idle_pct = 6;
		sink_idle_pct = 49;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_INSERT;
		req_ch.key = '0;
		req_ch.payload = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_cases();
		test_full_empty();
		test_random_mix(450);

		src_idle_pct = 49;
		sink_idle_pct = 6;
		test_random_mix(500);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_mix(500);

		wait_all_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && heap_expect.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/hmq_pkg.sv
rtl/hmq_ifs.sv
rtl/hmq_cell.sv
rtl/binary_min_heap_queue.sv
dv/tb_binary_min_heap_queue.sv
